@@ rtl/core/pba_pkg.sv @@
// shared constants, types and helpers of the page bitmap allocator
package pba_pkg;

	localparam int PAGE_BITS     = 16;
	localparam int WORD_BITS     = 64;
	localparam int IDX_BITS      = $clog2(WORD_BITS);
	localparam int WADDR_BITS    = PAGE_BITS - IDX_BITS;
	localparam int WORD_COUNT    = 1 << WADDR_BITS;
	localparam int ROW_IDX_BITS  = IDX_BITS;
	localparam int ROW_BITS      = WADDR_BITS - ROW_IDX_BITS;
	localparam int ROW_COUNT     = 1 << ROW_BITS;
	localparam logic [PAGE_BITS-1:0] SEARCH_START_RESET = PAGE_BITS'(256);

	typedef enum logic [1:0] {
		CMD_QUERY   = 2'd0,
		CMD_RESERVE = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_ALLOC   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [WADDR_BITS-1:0] bm_raddr;
		logic [ROW_BITS-1:0]   sm_raddr;
		logic                  upd;
		logic [PAGE_BITS-1:0]  upd_page;
		logic                  upd_set;
	} store_req_t;

	typedef struct packed {
		logic                  clearing;
		logic [WORD_BITS-1:0]  bm_rdata;
		logic [WORD_BITS-1:0]  sm_rdata;
	} store_rsp_t;

	// index of the lowest set bit, zero when none is set
	function automatic logic [IDX_BITS-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
		logic [IDX_BITS-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) idx = IDX_BITS'(i);
		end
		return idx;
	endfunction

endpackage

@@ rtl/core/pba_store.sv @@
// bitmap and word-full summary memories with clearing pass and bit update
module pba_store (
	input  logic              clk,
	input  logic              arst_n,
	input  pba_pkg::store_req_t req,
	output pba_pkg::store_rsp_t rsp
);
	import pba_pkg::*;

	logic [WORD_BITS-1:0]  bm_mem [WORD_COUNT];
	logic [WORD_BITS-1:0]  sm_mem [ROW_COUNT];
	logic [WORD_BITS-1:0]  bm_rdata_q;
	logic [WORD_BITS-1:0]  sm_rdata_q;
	logic                  clearing_q;
	logic [WADDR_BITS-1:0] clr_cnt_q;

	logic [WADDR_BITS-1:0]   upd_word;
	logic [ROW_BITS-1:0]     upd_row;
	logic [ROW_IDX_BITS-1:0] upd_pos;
	logic [IDX_BITS-1:0]     upd_bit;
	logic [WORD_BITS-1:0]    new_word;
	logic [WORD_BITS-1:0]    new_sum;

	assign upd_word = req.upd_page[PAGE_BITS-1 -: WADDR_BITS];
	assign upd_row  = upd_word[WADDR_BITS-1 -: ROW_BITS];
	assign upd_pos  = upd_word[ROW_IDX_BITS-1:0];
	assign upd_bit  = req.upd_page[IDX_BITS-1:0];

	// modify the word read in the previous cycle and refresh its full flag
	always_comb begin
		new_word = bm_rdata_q;
		new_word[upd_bit] = req.upd_set;
		new_sum = sm_rdata_q;
		new_sum[upd_pos] = &new_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == WADDR_BITS'(WORD_COUNT - 1)) clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			bm_mem[clr_cnt_q] <= '0;
			sm_mem[clr_cnt_q[ROW_BITS-1:0]] <= '0;
		end else if (req.upd) begin
			bm_mem[upd_word] <= new_word;
			sm_mem[upd_row]  <= new_sum;
		end
	end

	always_ff @(posedge clk) begin
		bm_rdata_q <= bm_mem[req.bm_raddr];
		sm_rdata_q <= sm_mem[req.sm_raddr];
	end

	assign rsp.clearing = clearing_q;
	assign rsp.bm_rdata = bm_rdata_q;
	assign rsp.sm_rdata = sm_rdata_q;

endmodule

@@ rtl/core/page_bitmap_allocator.sv @@
// top level of the page bitmap allocator: command sequencer and result registers
//
// one bit per page frame (1 reserved, 0 free) lives in a 1024 x 64 synchronous
// memory, with a 16 x 64 summary memory holding one "word full" flag per
// bitmap word. after reset a clearing pass zeroes both memories; busy stays
// high during it and config writes are still taken. a command is taken when
// start is high and busy is low. every item returns exactly one result,
// shown for a single cycle with done high; the receiver cannot stall it. an
// item first looks for a free page at or above the start in the search start
// word. otherwise the summary rows from the start row up are scanned one per
// cycle; when a row with a free word turns up, that word is read for its
// lowest free page. allocate with nothing free skips the write-back. the
// summary row scan is what sets the length of an item. busy is low in the
// cycle that shows the result, so the next item can be taken at the edge
// that ends it. found and free_page always describe the bitmap before the
// command takes effect.
module page_bitmap_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    cmd,
	input  logic [pba_pkg::PAGE_BITS-1:0] page_index,
	input  logic                          cfg_we,
	input  logic [pba_pkg::PAGE_BITS-1:0] cfg_wdata,
	output logic                          done,
	output logic                          was_free,
	output logic                          found,
	output logic [pba_pkg::PAGE_BITS-1:0] free_page
);
	import pba_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_FIRST  = 6'b000010,
		ST_SUM    = 6'b000100,
		ST_FOUNDW = 6'b001000,
		ST_OPRD   = 6'b010000,
		ST_OPWR   = 6'b100000
	} state_t;

	state_t                st_q;
	logic [PAGE_BITS-1:0]  search_start_q;
	logic [PAGE_BITS-1:0]  start_q;
	cmd_t                  cmd_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic [ROW_BITS-1:0]   row_q;
	logic [WADDR_BITS-1:0] word_q;
	logic                  srch_found_q;
	logic [PAGE_BITS-1:0]  srch_page_q;

	logic                  done_q;
	logic                  was_free_q;
	logic                  found_q;
	logic [PAGE_BITS-1:0]  free_page_q;

	store_req_t            store_req;
	store_rsp_t            store_rsp;

	logic                    accept;
	logic [WADDR_BITS-1:0]   start_word;
	logic [ROW_BITS-1:0]     start_row;
	logic [ROW_IDX_BITS-1:0] start_pos;
	logic [WORD_BITS-1:0]    first_free;
	logic [WORD_BITS-1:0]    row_mask;
	logic [WORD_BITS-1:0]    row_avail;
	logic [WADDR_BITS-1:0]   hit_word;
	logic [PAGE_BITS-1:0]    tgt_page;

	assign busy   = store_rsp.clearing || (st_q != ST_IDLE);
	assign accept = start && !busy;

	assign start_word = start_q[PAGE_BITS-1 -: WADDR_BITS];
	assign start_row  = start_word[WADDR_BITS-1 -: ROW_BITS];
	assign start_pos  = start_word[ROW_IDX_BITS-1:0];

	// free bits of the start word at or above the start bit
	assign first_free = ~store_rsp.bm_rdata & ({WORD_BITS{1'b1}} << start_q[IDX_BITS-1:0]);

	// in the start row only words past the start word count
	assign row_mask  = (row_q == start_row)
		? (({WORD_BITS{1'b1}} << start_pos) << 1) : {WORD_BITS{1'b1}};
	assign row_avail = ~store_rsp.sm_rdata & row_mask;
	assign hit_word  = {row_q, lowest_set(row_avail)};

	// allocate acts on the page found, the other commands on the named page
	assign tgt_page = (cmd_q == CMD_ALLOC) ? srch_page_q : page_q;

	always_comb begin
		store_req.bm_raddr = tgt_page[PAGE_BITS-1 -: WADDR_BITS];
		store_req.sm_raddr = tgt_page[PAGE_BITS-1 -: ROW_BITS];
		store_req.upd      = 1'b0;
		store_req.upd_page = tgt_page;
		store_req.upd_set  = (cmd_q != CMD_RELEASE);
		unique case (st_q)
			ST_IDLE: begin
				// keep reading the start word so it is ready right after accept
				store_req.bm_raddr = search_start_q[PAGE_BITS-1 -: WADDR_BITS];
			end
			ST_FIRST: begin
				store_req.sm_raddr = start_row;
			end
			ST_SUM: begin
				store_req.sm_raddr = row_q + 1'b1;
				store_req.bm_raddr = hit_word;
			end
			ST_OPWR: begin
				store_req.upd = (cmd_q != CMD_QUERY);
			end
			default: begin
			end
		endcase
	end

	pba_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (store_req),
		.rsp    (store_rsp)
	);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_start_q <= SEARCH_START_RESET;
		end else if (cfg_we) begin
			search_start_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (accept) st_q <= ST_FIRST;
				end
				ST_FIRST: begin
					if (|first_free) begin
						st_q <= ST_OPRD;
					end else if (start_word == WADDR_BITS'(WORD_COUNT - 1)) begin
						st_q <= ST_OPRD;
					end else begin
						st_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (|row_avail) begin
						st_q <= ST_FOUNDW;
					end else if (row_q == ROW_BITS'(ROW_COUNT - 1)) begin
						st_q <= ST_OPRD;
					end
				end
				ST_FOUNDW: begin
					st_q <= ST_OPRD;
				end
				ST_OPRD: begin
					// allocate with nothing free: report and change nothing
					if (cmd_q == CMD_ALLOC && !srch_found_q) begin
						st_q   <= ST_IDLE;
						done_q <= 1'b1;
					end else begin
						st_q <= ST_OPWR;
					end
				end
				ST_OPWR: begin
					st_q   <= ST_IDLE;
					done_q <= 1'b1;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item and search payload
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q        <= cmd_t'(cmd);
					page_q       <= page_index;
					start_q      <= search_start_q;
					srch_found_q <= 1'b0;
					srch_page_q  <= '0;
				end
			end
			ST_FIRST: begin
				row_q <= start_row;
				if (|first_free) begin
					srch_found_q <= 1'b1;
					srch_page_q  <= {start_word, lowest_set(first_free)};
				end
			end
			ST_SUM: begin
				row_q  <= row_q + 1'b1;
				word_q <= hit_word;
			end
			ST_FOUNDW: begin
				srch_found_q <= 1'b1;
				srch_page_q  <= {word_q, lowest_set(~store_rsp.bm_rdata)};
			end
			ST_OPRD: begin
				if (cmd_q == CMD_ALLOC && !srch_found_q) begin
					was_free_q  <= 1'b0;
					found_q     <= 1'b0;
					free_page_q <= '0;
				end
			end
			ST_OPWR: begin
				was_free_q  <= ~store_rsp.bm_rdata[tgt_page[IDX_BITS-1:0]];
				found_q     <= srch_found_q;
				free_page_q <= srch_page_q;
			end
			default: begin
			end
		endcase
	end

	assign done      = done_q;
	assign was_free  = was_free_q;
	assign found     = found_q;
	assign free_page = free_page_q;

	// no free page reported means the page field reads zero
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> free_page == '0)
		else $error("free_page not zero without a found page");

	// the write-back state always ends in a result
	a_wr_done: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_OPWR |=> done)
		else $error("write-back without a result");

	// a successful allocate always reports the page as free
	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_OPWR && cmd_q == CMD_ALLOC |=> was_free && found)
		else $error("allocated page was not free");

	// no item runs while the clearing pass is active
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		store_rsp.clearing |-> st_q == ST_IDLE && !done)
		else $error("item in flight during clearing pass");

endmodule

@@ sim/tb.sv @@
// self-checking testbench of the page bitmap allocator: driver, monitor and bitmap predictor
`timescale 1ns / 100ps

module tb;
	import pba_pkg::*;

	// generous bound: clearing pass plus 506 items at the slowest search and idle gaps
	localparam int CYCLE_LIMIT  = 200000;
	// settle time after the last result, longer than the slowest item
	localparam int SETTLE_CYCLES = 30;
	localparam int PHASE_ITEMS  = 48;
	localparam int RANDOM_PHASES = 10;

	// one command item as the driver presents it
	typedef struct packed {
		cmd_t                 op;
		logic [PAGE_BITS-1:0] page;
	} page_cmd_t;

	// one result item as the block reports it
	typedef struct packed {
		logic                 was_free;
		logic                 found;
		logic [PAGE_BITS-1:0] free_page;
	} page_report_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [1:0]           cmd = CMD_QUERY;
	logic [PAGE_BITS-1:0] page_index = '0;
	logic                 cfg_we = 1'b0;
	logic [PAGE_BITS-1:0] cfg_wdata = '0;
	logic                 done;
	logic                 was_free;
	logic                 found;
	logic [PAGE_BITS-1:0] free_page;

	page_bitmap_allocator uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.page_index (page_index),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.was_free   (was_free),
		.found      (found),
		.free_page  (free_page)
	);

	// commands waiting for the driver, and reports predicted but not yet seen
	page_cmd_t    cmd_queue[$];
	page_report_t pending_reports[$];

	// predictor state: its own copy of the bitmap and of the search start
	bit [WORD_BITS-1:0]   page_words [WORD_COUNT];
	logic [PAGE_BITS-1:0] search_start = SEARCH_START_RESET;

	int        errors = 0;
	int        sent_items = 0;
	int        checked_items = 0;
	int        alloc_hits = 0;
	int        alloc_misses = 0;
	int        cfg_writes = 0;
	int        cycle_count = 0;
	bit        no_idle = 1'b0;
	logic      item_taken = 1'b0;
	page_cmd_t next_cmd;

	initial begin
		forever #5 clk = ~clk;
	end

	// predicts one command: the search looks at the bitmap as it stood before
	// the command, then the command updates the bitmap
	function automatic page_report_t apply_page_cmd(cmd_t op, logic [PAGE_BITS-1:0] pg);
		page_report_t       rep;
		logic [WORD_BITS-1:0] open_bits;
		int unsigned        first_word;
		bit                 hit;
		rep = '0;
		hit = 1'b0;
		first_word = search_start[PAGE_BITS-1:IDX_BITS];
		// free pages of the first word, masked below the start bit
		open_bits = ~page_words[first_word] & ({WORD_BITS{1'b1}} << search_start[IDX_BITS-1:0]);
		for (int unsigned k = first_word; k < WORD_COUNT && !hit; k++) begin
			if (k != first_word)
				open_bits = ~page_words[k];
			if (open_bits != '0) begin
				for (int unsigned j = 0; j < WORD_BITS && !hit; j++) begin
					if (open_bits[j]) begin
						hit = 1'b1;
						rep.found = 1'b1;
						rep.free_page = PAGE_BITS'(k * WORD_BITS + j);
					end
				end
			end
		end
		if (op == CMD_ALLOC) begin
			// allocate addresses the page it found, so was_free follows found
			rep.was_free = rep.found;
			if (rep.found)
				page_words[rep.free_page[PAGE_BITS-1:IDX_BITS]][rep.free_page[IDX_BITS-1:0]] = 1'b1;
		end else begin
			rep.was_free = ~page_words[pg[PAGE_BITS-1:IDX_BITS]][pg[IDX_BITS-1:0]];
			case (op)
				CMD_RESERVE: page_words[pg[PAGE_BITS-1:IDX_BITS]][pg[IDX_BITS-1:0]] = 1'b1;
				CMD_RELEASE: page_words[pg[PAGE_BITS-1:IDX_BITS]][pg[IDX_BITS-1:0]] = 1'b0;
				default: ;
			endcase
		end
		return rep;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_val,
			input int unsigned act_val);
		if (exp_val != act_val) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name,
				exp_val, act_val);
		end
	endtask

	// driver: a new item goes out at the falling edge once the previous one was
	// taken; start stays high across back-to-back items without dropping
	always @(negedge clk) begin
		if (arst_n && (!start || item_taken)) begin
			if (cmd_queue.size() != 0 && (no_idle || $urandom_range(99) >= 6)) begin
				next_cmd = cmd_queue.pop_front();
				start <= 1'b1;
				cmd <= next_cmd.op;
				page_index <= next_cmd.page;
				sent_items++;
			end else begin
				start <= 1'b0;
				// idle cycles still toggle the ignored page index
				page_index <= PAGE_BITS'($urandom_range(65535));
			end
		end
	end

	// monitor: results are checked before the item taken at the same edge is
	// predicted, so the oldest report is always the one due
	always @(posedge clk) begin
		if (!arst_n) begin
			item_taken <= 1'b0;
		end else begin
			item_taken <= start && !busy;
			if (done) begin
				if (pending_reports.size() == 0) begin
					errors++;
					$display("%0t ns: result with no item outstanding, was_free %0d found %0d free_page %0d",
						$time, was_free, found, free_page);
				end else begin
					check_field("was_free", pending_reports[0].was_free, was_free);
					check_field("found", pending_reports[0].found, found);
					check_field("free_page", pending_reports[0].free_page, free_page);
					void'(pending_reports.pop_front());
					checked_items++;
				end
			end
			// config writes only happen while idle, never beside a command
			if (cfg_we)
				search_start = cfg_wdata;
			if (start && !busy) begin
				pending_reports.push_back(apply_page_cmd(cmd_t'(cmd), page_index));
				if (cmd_t'(cmd) == CMD_ALLOC) begin
					if (pending_reports[pending_reports.size()-1].found)
						alloc_hits++;
					else
						alloc_misses++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
				pending_reports.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic push_cmd(input cmd_t op, input logic [PAGE_BITS-1:0] pg);
		page_cmd_t c;
		c.op = op;
		c.page = pg;
		cmd_queue.push_back(c);
	endtask

	// waits until every item went out and every report came back
	task automatic wait_idle();
		while (cmd_queue.size() != 0 || start || pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_search_start(input logic [PAGE_BITS-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= PAGE_BITS'($urandom_range(65535));
		cfg_writes++;
	endtask

	// random items clustered around the search start so allocates, reserves and
	// releases hit the same words, with some fully random pages mixed in
	task automatic random_phase(input logic [PAGE_BITS-1:0] window, input int count);
		int unsigned   r;
		cmd_t          op;
		logic [PAGE_BITS-1:0] pg;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 40)
				op = CMD_ALLOC;
			else if (r < 62)
				op = CMD_RESERVE;
			else if (r < 78)
				op = CMD_RELEASE;
			else
				op = CMD_QUERY;
			r = $urandom_range(9);
			if (r < 5)
				pg = PAGE_BITS'(window + $urandom_range(319) - 64);
			else if (r < 8)
				pg = PAGE_BITS'($urandom_range(65535));
			else if (r < 9)
				pg = $urandom_range(1) ? '0 : '1;
			else
				pg = $urandom_range(1) ? window : PAGE_BITS'(window - 1);
			push_cmd(op, pg);
		end
	endtask

	initial begin
		logic [PAGE_BITS-1:0] phase_start;

		// single reset at the start
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		// let the clearing pass finish before touching the config
		@(posedge clk);
		while (busy)
			@(posedge clk);

		// directed, reset search start: queries, reserve of the found page,
		// allocate runs, releases and both ends of the page range
		push_cmd(CMD_QUERY, 16'd0);
		push_cmd(CMD_QUERY, 16'hFFFF);
		push_cmd(CMD_QUERY, 16'd256);
		push_cmd(CMD_RESERVE, 16'd256);
		push_cmd(CMD_QUERY, 16'd256);
		push_cmd(CMD_RESERVE, 16'd256);
		push_cmd(CMD_ALLOC, 16'hFFFF);
		push_cmd(CMD_ALLOC, 16'd0);
		push_cmd(CMD_RELEASE, 16'd257);
		push_cmd(CMD_ALLOC, 16'd1234);
		push_cmd(CMD_RELEASE, 16'd256);
		push_cmd(CMD_QUERY, 16'd256);
		push_cmd(CMD_RESERVE, 16'hFFFF);
		push_cmd(CMD_RESERVE, 16'd0);
		push_cmd(CMD_QUERY, 16'hFFFF);
		push_cmd(CMD_RELEASE, 16'hFFFF);
		push_cmd(CMD_RELEASE, 16'd0);
		push_cmd(CMD_RELEASE, 16'd1);
		wait_idle();

		// top of the range: the last page, then allocate with nothing free
		write_search_start(16'hFFFF);
		push_cmd(CMD_ALLOC, 16'd5);
		push_cmd(CMD_ALLOC, 16'hFFFF);
		push_cmd(CMD_QUERY, 16'hFFFF);
		push_cmd(CMD_RELEASE, 16'hFFFF);
		push_cmd(CMD_ALLOC, 16'd0);
		push_cmd(CMD_RELEASE, 16'hFFFF);
		wait_idle();

		// bottom of the range
		write_search_start(16'd0);
		push_cmd(CMD_ALLOC, 16'hAAAA);
		push_cmd(CMD_QUERY, 16'd0);
		wait_idle();

		// random phases over extreme, fixed and random search starts
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: phase_start = 16'd0;
				1: phase_start = 16'hFFFF;
				2: phase_start = 16'd256;
				3: phase_start = 16'hFFC0;
				4: phase_start = 16'd64;
				5: phase_start = 16'd63;
				6: phase_start = PAGE_BITS'(256 + $urandom_range(255));
				7: phase_start = 16'd300;
				default: phase_start = PAGE_BITS'($urandom_range(65535));
			endcase
			// one phase runs with no idle cycles on the driver
			no_idle = (p == 4);
			write_search_start(phase_start);
			random_phase(phase_start, PHASE_ITEMS);
			wait_idle();
		end
		no_idle = 1'b0;

		$display("%0d items sent, %0d results checked, %0d config writes", sent_items,
			checked_items, cfg_writes);
		$display("allocates: %0d found a page, %0d found none", alloc_hits, alloc_misses);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
